// ===== rtl/core/b64c_pkg.sv =====
package b64c_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;  // '='
  localparam logic [7:0] PlusChar  = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar = 8'h2F;  // '/'

  localparam int unsigned MaxResults = 4;

  // Direction register codes.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // One group's worth of results, handed from the group unit to the output stage.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] data;  // data[0] goes out first
    logic [2:0]                 num;   // 1 to 4 results
    logic                       last;  // final result of the burst ends the message
    logic                       err;   // decode length error result
  } burst_t;

  // Sextet to character, standard alphabet.
  function automatic logic [7:0] enc_char(input logic [5:0] sx);
    logic [7:0] v;
    v = {2'b00, sx};
    if (sx < 6'd26) begin
      enc_char = 8'h41 + v;
    end else if (sx < 6'd52) begin
      enc_char = 8'h61 + v - 8'd26;
    end else if (sx < 6'd62) begin
      enc_char = 8'h30 + v - 8'd52;
    end else if (sx == 6'd62) begin
      enc_char = PlusChar;
    end else begin
      enc_char = SlashChar;
    end
  endfunction

  // Character to sextet; anything outside the alphabet, the pad mark too, is zero.
  function automatic logic [5:0] dec_sextet(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'd0;
    case (ch) inside
      [8'h41:8'h5A]: v = ch - 8'h41;
      [8'h61:8'h7A]: v = ch - 8'h61 + 8'd26;
      [8'h30:8'h39]: v = ch - 8'h30 + 8'd52;
      PlusChar:      v = 8'd62;
      SlashChar:     v = 8'd63;
      default:       v = 8'd0;
    endcase
    dec_sextet = v[5:0];
  endfunction

endpackage

// ===== rtl/core/b64c_group.sv =====
module b64c_group (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             dir_i,
  input  logic             clear_i,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             burst_valid_o,
  output b64c_pkg::burst_t burst_o
);

  logic [23:0] bits_q, bits_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        tpad_q, tpad_d;

  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [5:0]  sx;
  logic        is_pad;

  assign is_pad = (byte_i == b64c_pkg::PadChar);
  assign sx     = is_pad ? 6'd0 : b64c_pkg::dec_sextet(byte_i);

  always_comb begin
    case (cnt_q)
      2'd0:    enc_bits = bits_q | {byte_i, 16'h0000};
      2'd1:    enc_bits = bits_q | {8'h00, byte_i, 8'h00};
      default: enc_bits = bits_q | {16'h0000, byte_i};
    endcase
    case (cnt_q)
      2'd0:    dec_bits = bits_q | {sx, 18'd0};
      2'd1:    dec_bits = bits_q | {6'd0, sx, 12'd0};
      2'd2:    dec_bits = bits_q | {12'd0, sx, 6'd0};
      default: dec_bits = bits_q | {18'd0, sx};
    endcase
  end

  always_comb begin
    bits_d        = bits_q;
    cnt_d         = cnt_q;
    tpad_d        = tpad_q;
    burst_valid_o = 1'b0;
    burst_o       = '0;

    if (clear_i) begin
      bits_d = '0;
      cnt_d  = '0;
      tpad_d = 1'b0;
    end else if (accept_i) begin
      if (dir_i == b64c_pkg::DirEncode) begin
        if (cnt_q == 2'd2 || last_i) begin
          burst_valid_o   = 1'b1;
          burst_o.num     = 3'd4;
          burst_o.last    = last_i;
          burst_o.data[0] = b64c_pkg::enc_char(enc_bits[23:18]);
          burst_o.data[1] = b64c_pkg::enc_char(enc_bits[17:12]);
          // A partial group pads the tail: one byte gives two marks, two bytes give one.
          burst_o.data[2] = (cnt_q == 2'd0) ? b64c_pkg::PadChar
                                            : b64c_pkg::enc_char(enc_bits[11:6]);
          burst_o.data[3] = (cnt_q != 2'd2) ? b64c_pkg::PadChar
                                            : b64c_pkg::enc_char(enc_bits[5:0]);
          bits_d = '0;
          cnt_d  = '0;
          tpad_d = 1'b0;
        end else begin
          bits_d = enc_bits;
          cnt_d  = cnt_q + 2'd1;
        end
      end else begin
        if (cnt_q != 2'd3) begin
          if (last_i) begin
            burst_valid_o = 1'b1;
            burst_o.num   = 3'd1;
            burst_o.last  = 1'b1;
            burst_o.err   = 1'b1;
            bits_d = '0;
            cnt_d  = '0;
            tpad_d = 1'b0;
          end else begin
            bits_d = dec_bits;
            cnt_d  = cnt_q + 2'd1;
            if (cnt_q == 2'd2) begin
              tpad_d = is_pad;
            end
          end
        end else begin
          burst_valid_o   = 1'b1;
          burst_o.last    = last_i;
          burst_o.data[0] = dec_bits[23:16];
          burst_o.data[1] = dec_bits[15:8];
          burst_o.data[2] = dec_bits[7:0];
          // Only the final group of a message is shortened by padding.
          if (last_i && is_pad) begin
            burst_o.num = tpad_q ? 3'd1 : 3'd2;
          end else begin
            burst_o.num = 3'd3;
          end
          bits_d = '0;
          cnt_d  = '0;
          tpad_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      cnt_q  <= '0;
      tpad_q <= 1'b0;
    end else begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      tpad_q <= tpad_d;
    end
  end

endmodule

// ===== rtl/core/b64c_emit.sv =====
module b64c_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  b64c_pkg::burst_t burst_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [7:0]       byte_o,
  output logic             last_o,
  output logic             err_o
);

  b64c_pkg::burst_t buf_q;
  logic             valid_q, valid_d;
  logic [1:0]       idx_q, idx_d;
  logic             take;
  logic             final_item;

  assign take       = valid_q && ready_i;
  assign final_item = ({1'b0, idx_q} == (buf_q.num - 3'd1));
  // A new burst may enter in the cycle the last result of the current one leaves.
  assign free_o     = !valid_q || (take && final_item);

  assign valid_o = valid_q;
  assign byte_o  = buf_q.data[idx_q];
  assign last_o  = buf_q.last && final_item;
  assign err_o   = buf_q.err;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (final_item) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= burst_i;
    end
  end

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && buf_q.err |-> last_o && byte_o == 8'h00)
    else $error("length error result must be a lone final zero");

  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> buf_q.num != 3'd0 && buf_q.num <= 3'd4)
    else $error("burst holds an impossible result count");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("burst loaded over results not yet delivered");

  a_idx_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !final_item && !load_i |=> valid_q && idx_q == $past(idx_q) + 2'd1)
    else $error("result index did not advance");

endmodule

// ===== rtl/core/base64_codec.sv =====
// Streaming Base64 codec, standard alphabet. cfg_wdata_i selects encode (0) or decode (1);
// a write also drops any partial group, so write it only between messages. Input items are
// taken one per cycle while the result register is free; when an item completes a group
// (or ends a message) its results, four characters when encoding, up to three bytes or one
// length-error result when decoding, are loaded into the result register at the accepting
// edge and leave one per cycle, while m_axis_tready is high, from the next cycle on. The
// input stalls whenever that register holds results, except in the cycle its final result
// leaves, so groups never overlap. s_axis_tready depends combinationally on m_axis_tready.
// The length-error result carries data 0, tlast and tuser set.
module base64_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // direction
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser     // [0] length_error
);

  logic             dir_q;
  logic             in_accept;
  logic             burst_valid;
  logic             emit_free;
  b64c_pkg::burst_t burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= b64c_pkg::DirEncode;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = emit_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  b64c_group u_group (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dir_i         (dir_q),
    .clear_i       (cfg_we_i),
    .accept_i      (in_accept),
    .byte_i        (s_axis_tdata),
    .last_i        (s_axis_tlast),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  b64c_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (burst_valid),
    .burst_i (burst),
    .free_o  (emit_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .err_o   (m_axis_tuser)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 150;

  // First character sits in the top byte.
  localparam logic [8*64-1:0] Base64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } b64_out_t;

  typedef enum logic {RowItem, RowDir} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic        typed;   // results below are given by hand
    logic [2:0]  nres;
    logic [31:0] chars;   // first result in the top byte
    logic        err;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] in_byte
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] out_byte
  logic       m_axis_tlast;
  logic       m_axis_tuser;   // [0] length_error

  base64_codec u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // Codec state as the block should hold it.
  logic        dir_q;
  logic [23:0] grp_bits;
  logic [1:0]  grp_cnt;
  logic        third_pad;

  b64_out_t   b64_out_q[$];
  b64_out_t   step_out[$];
  row_t       rows[$];
  logic [7:0] msg_q[$];

  bit burst_mode;
  int unsigned cycle_count;
  int item_count;
  int directed_count;
  int dir_writes;
  int result_count;
  int err_results;
  int mismatches;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] sx);
    return Base64Alphabet[8 * (63 - sx) +: 8];
  endfunction

  function automatic logic [5:0] char_sextet(input logic [7:0] ch);
    logic [5:0] sx;
    sx = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (Base64Alphabet[8 * (63 - k) +: 8] == ch) sx = k[5:0];
    end
    return sx;
  endfunction

  function automatic int gap_len();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic drop_group();
    grp_bits  = 24'd0;
    grp_cnt   = 2'd0;
    third_pad = 1'b0;
  endtask

  // Advances the codec state by one input item and leaves its results in step_out.
  task automatic b64_step(input logic [7:0] b, input logic l);
    b64_out_t r;
    int       nout;
    logic     pad;
    logic [5:0] sx;
    step_out.delete();
    if (dir_q == b64c_pkg::DirEncode) begin
      grp_bits = grp_bits | ({16'd0, b} << (16 - 8 * grp_cnt));
      if (grp_cnt < 2'd2 && !l) begin
        grp_cnt = grp_cnt + 2'd1;
      end else begin
        nout = grp_cnt + 2;
        for (int k = 0; k < 4; k++) begin
          r.data = (k < nout) ? sextet_char(grp_bits[23 - 6 * k -: 6]) : b64c_pkg::PadChar;
          r.last = l && (k == 3);
          r.err  = 1'b0;
          step_out.push_back(r);
        end
        drop_group();
      end
    end else begin
      pad = (b == b64c_pkg::PadChar);
      sx  = pad ? 6'd0 : char_sextet(b);
      if (grp_cnt != 2'd3) begin
        if (l) begin
          // Message ended inside a group.
          r.data = 8'h00;
          r.last = 1'b1;
          r.err  = 1'b1;
          step_out.push_back(r);
          drop_group();
        end else begin
          grp_bits = grp_bits | ({18'd0, sx} << (18 - 6 * grp_cnt));
          if (grp_cnt == 2'd2) third_pad = pad;
          grp_cnt = grp_cnt + 2'd1;
        end
      end else begin
        grp_bits = grp_bits | {18'd0, sx};
        nout = 3;
        if (l && pad) nout = third_pad ? 1 : 2;
        for (int k = 0; k < nout; k++) begin
          r.data = grp_bits[23 - 8 * k -: 8];
          r.last = l && (k == nout - 1);
          r.err  = 1'b0;
          step_out.push_back(r);
        end
        drop_group();
      end
    end
  endtask

  task automatic add_row(input row_kind_e kind, input logic [7:0] data, input logic last,
                         input logic typed, input logic [2:0] nres, input logic [31:0] chars,
                         input logic err);
    row_t rw;
    rw.kind  = kind;
    rw.data  = data;
    rw.last  = last;
    rw.typed = typed;
    rw.nres  = nres;
    rw.chars = chars;
    rw.err   = err;
    rows.push_back(rw);
  endtask

  task automatic set_direction(input logic v);
    s_axis_tvalid <= 1'b0;
    while (b64_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dir_q = v;
    drop_group();
    dir_writes++;
  endtask

  task automatic push_item(input logic [7:0] d, input logic l, input logic typed,
                           input logic [2:0] n, input logic [31:0] chars, input logic err);
    b64_out_t r;
    int       g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    item_count++;
    b64_step(d, l);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        r.data = chars[31 - 8 * k -: 8];
        r.last = l && (k == n - 1);
        r.err  = err;
        b64_out_q.push_back(r);
      end
    end else begin
      foreach (step_out[k]) b64_out_q.push_back(step_out[k]);
    end
  endtask

  always @(posedge clk_i) begin
    b64_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (m_axis_tuser) err_results++;
      if (b64_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: data %02h last %b err %b", $time,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = b64_out_q.pop_front();
        if (want.data !== m_axis_tdata || want.last !== m_axis_tlast ||
            want.err !== m_axis_tuser) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected data %02h last %b err %b, got %02h %b %b",
                     $time, want.data, want.last, want.err,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  initial begin : sink
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 1) == 0) stall = gap_len();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  initial begin : stim
    logic [7:0] ch;
    int len;
    int pads;
    int kind;
    int phase;

    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    burst_mode    = 1'b0;
    dir_q         = b64c_pkg::DirEncode;
    drop_group();

    // Encoding from reset: a full group, both partial tails, all-ones and all-zeros bytes.
    add_row(RowItem, 8'hFF, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, 8'hFF, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, 8'hFF, 1'b0, 1'b1, 3'd4, "////", 1'b0);
    add_row(RowItem, 8'h00, 1'b1, 1'b1, 3'd4, "AA==", 1'b0);
    add_row(RowItem, 8'hFF, 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, 8'hFF, 1'b1, 1'b1, 3'd4, "//8=", 1'b0);
    add_row(RowDir,  {7'd0, b64c_pkg::DirDecode}, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
    // Decoding: no pad, one pad, two pads.
    add_row(RowItem, "/", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "/", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "/", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "/", 1'b1, 1'b1, 3'd3, 32'hFFFFFF00, 1'b0);
    add_row(RowItem, "/", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "/", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "8", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "=", 1'b1, 1'b1, 3'd2, 32'hFFFF0000, 1'b0);
    add_row(RowItem, "A", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "A", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "=", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "=", 1'b1, 1'b1, 3'd1, 32'd0, 1'b0);
    // Characters outside the alphabet and a pad in third place that does not end the group.
    add_row(RowItem, 8'h00, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, 8'hFF, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "=",   1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "C",   1'b1, 1'b0, 3'd0, 32'd0, 1'b0);
    // Length error after two characters.
    add_row(RowItem, "A", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "B", 1'b1, 1'b1, 3'd1, 32'd0, 1'b1);
    // A direction write drops the half-filled group.
    add_row(RowItem, "Q", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, "U", 1'b0, 1'b1, 3'd0, 32'd0, 1'b0);
    add_row(RowDir,  {7'd0, b64c_pkg::DirEncode}, 1'b0, 1'b0, 3'd0, 32'd0, 1'b0);
    add_row(RowItem, 8'hFF, 1'b1, 1'b1, 3'd4, "/w==", 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == RowDir) set_direction(rows[i].data[0]);
      else push_item(rows[i].data, rows[i].last, rows[i].typed, rows[i].nres,
                     rows[i].chars, rows[i].err);
    end
    directed_count = item_count;

    phase = 0;
    while (item_count - directed_count < RandomItems) begin
      set_direction((phase % 2 == 0) ? b64c_pkg::DirDecode : b64c_pkg::DirEncode);
      repeat ($urandom_range(3, 6)) begin
        msg_q.delete();
        kind = $urandom_range(0, 99);
        if (dir_q == b64c_pkg::DirEncode) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
          repeat (len) begin
            ch = 8'($urandom);
            msg_q.push_back(ch);
          end
        end else if (kind < 75) begin
          // Whole groups, mostly alphabet characters, the tail padded with zero to two marks.
          len  = 4 * $urandom_range(1, 4);
          pads = $urandom_range(0, 2);
          for (int k = 0; k < len; k++) begin
            ch = Base64Alphabet[8 * $urandom_range(0, 63) +: 8];
            if (k >= len - pads) ch = b64c_pkg::PadChar;
            else if ($urandom_range(0, 19) == 0) ch = b64c_pkg::PadChar;
            else if ($urandom_range(0, 19) == 0) ch = 8'($urandom);
            msg_q.push_back(ch);
          end
        end else begin
          len = $urandom_range(1, 9);
          repeat (len) begin
            case ($urandom_range(0, 3))
              0:       ch = b64c_pkg::PadChar;
              1:       ch = 8'($urandom);
              default: ch = Base64Alphabet[8 * $urandom_range(0, 63) +: 8];
            endcase
            msg_q.push_back(ch);
          end
        end
        burst_mode = ($urandom_range(0, 4) == 0);
        foreach (msg_q[k]) push_item(msg_q[k], k == msg_q.size() - 1, 1'b0, 3'd0, 32'd0, 1'b0);
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    burst_mode = 1'b0;
    while (b64_out_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d items (%0d directed) across %0d direction writes, both modes.",
             item_count, directed_count, dir_writes);
    $display("Checked %0d results, %0d length errors among them, %0d mismatches.",
             result_count, err_results, mismatches);
    if (mismatches == 0 && b64_out_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
